// ===== rtl/alab_pkg.sv =====
// ----------------------------------------------------------------------------
// alab_pkg
// Shared constants and the gamma table for the ambient light brightness block.
// ----------------------------------------------------------------------------
package alab_pkg;

    // Width of one brightness result.
    localparam int BRIGHT_W = 8;

    // Smallest brightness the block ever drives.
    localparam logic [BRIGHT_W-1:0] MIN_LEVEL = 8'd1;
    localparam logic [BRIGHT_W-1:0] MAX_LEVEL = 8'd255;

    // Gamma curve, indexed in reverse by the scaled window average.
    localparam logic [7:0] GAMMA_LUT [256] = '{
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,
        8'd6,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd9,   8'd9,   8'd10,  8'd10,
        8'd11,  8'd11,  8'd12,  8'd12,  8'd13,  8'd13,  8'd14,  8'd15,  8'd15,  8'd16,
        8'd16,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd21,  8'd21,  8'd22,
        8'd23,  8'd23,  8'd24,  8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,
        8'd30,  8'd30,  8'd31,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd36,  8'd36,
        8'd37,  8'd38,  8'd39,  8'd40,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd44,
        8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,  8'd51,  8'd52,  8'd53,
        8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
        8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,  8'd81,  8'd82,
        8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,  8'd89,  8'd90,  8'd91,  8'd92,
        8'd93,  8'd94,  8'd95,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103,
        8'd104, 8'd105, 8'd106, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112, 8'd113, 8'd114,
        8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd123, 8'd124, 8'd125, 8'd126,
        8'd127, 8'd128, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd136, 8'd137, 8'd138,
        8'd139, 8'd141, 8'd142, 8'd143, 8'd144, 8'd145, 8'd147, 8'd148, 8'd149, 8'd150,
        8'd152, 8'd153, 8'd154, 8'd156, 8'd157, 8'd158, 8'd159, 8'd161, 8'd162, 8'd163,
        8'd165, 8'd166, 8'd167, 8'd168, 8'd170, 8'd171, 8'd172, 8'd174, 8'd175, 8'd176,
        8'd178, 8'd179, 8'd180, 8'd182, 8'd183, 8'd184, 8'd186, 8'd187, 8'd188, 8'd190,
        8'd191, 8'd192, 8'd194, 8'd195, 8'd197, 8'd198, 8'd199, 8'd201, 8'd202, 8'd203,
        8'd205, 8'd206, 8'd208, 8'd209, 8'd210, 8'd212, 8'd213, 8'd215, 8'd216, 8'd218,
        8'd219, 8'd220, 8'd222, 8'd223, 8'd225, 8'd226, 8'd228, 8'd229, 8'd230, 8'd232,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244, 8'd245, 8'd247,
        8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd255
    };

endpackage

// ===== rtl/alab_stream_if.sv =====
// ----------------------------------------------------------------------------
// alab_sample_if / alab_level_if
// Valid/ready channels for light samples in and brightness items out.
// ----------------------------------------------------------------------------
interface alab_sample_if #(
    parameter int SAMPLE_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] light_sample;

    modport source (output valid, output light_sample, input ready);
    modport sink   (input valid, input light_sample, output ready);
endinterface

interface alab_level_if import alab_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BRIGHT_W-1:0] brightness;

    modport source (output valid, output brightness, input ready);
    modport sink   (input valid, input brightness, output ready);
endinterface

// ===== rtl/alab_ram.sv =====
// ----------------------------------------------------------------------------
// alab_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module alab_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 30,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ambient_light_auto_brightness.sv =====
// ----------------------------------------------------------------------------
// ambient_light_auto_brightness
// Moving average of light samples, scaled and mapped through a gamma curve.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one light sample per item; o_level returns one
//   brightness item for every sample, in order. The block works on one
//   item at a time: i_sample.ready is high only while it is idle.
//   After an accepted sample the window sum is updated one bit per cycle
//   in S_SUM, after S_LOAD; in S_DIV the scaled sum is then divided by
//   the fill count one quotient bit per cycle, after S_PREP. S_FIN loads
//   the result into the output register, and only then does the block
//   return to S_IDLE and take a new sample.
//   The result sits in an output register, so the next sample is taken
//   while o_level is stalled; a finished result waits in the last state
//   until the output register is free.
//   Reset empties the window: the sum, the fill count and the write slot
//   return to zero and no result is pending. The sample ring needs no
//   clearing, since a read entry is used only once every entry was written.
// ----------------------------------------------------------------------------
module ambient_light_auto_brightness import alab_pkg::*; #(
    parameter int WINDOW      = 30,
    parameter int SAMPLE_BITS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    alab_sample_if.sink  i_sample,
    alab_level_if.source o_level
);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int NUM_W = SUM_W + 8;
    localparam int QB    = (SAMPLE_BITS > 10) ? SAMPLE_BITS - 2 : 8;
    localparam int EXT_W = QB + CNT_W;
    localparam int CTR_W = $clog2((SUM_W > QB) ? SUM_W : QB);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_SUM  = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CTR_W-1:0] r_ctr, n_ctr;
    logic r_carry, n_carry;
    logic r_borrow, n_borrow;
    logic r_out_valid, n_out_valid;

    logic [SAMPLE_BITS-1:0] r_new, n_new;
    logic [SAMPLE_BITS-1:0] r_old, n_old;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [QB-1:0] r_dvd, n_dvd;
    logic [QB-1:0] r_q, n_q;
    logic [BRIGHT_W-1:0] r_brightness, n_brightness;

    logic accept;
    logic full;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic add_bit, sub_bit;
    logic [NUM_W-1:0] num;
    logic [EXT_W-1:0] a_ext;
    logic [CNT_W:0] trial, trial_diff;
    logic trial_ge;
    logic [7:0] x_val;
    logic [7:0] level;
    logic out_free;

    assign i_sample.ready = (r_state == S_IDLE);
    assign accept = i_sample.valid && i_sample.ready;
    assign full = (r_count == CNT_W'(WINDOW));
    assign out_free = !r_out_valid || o_level.ready;

    alab_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW),
        .ADDR_W(PTR_W)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (r_state == S_LOAD),
        .i_waddr(r_wptr),
        .i_wdata(r_new),
        .i_re   (accept),
        .i_raddr(r_wptr),
        .o_rdata(ram_rdata)
    );

    // Serial sum - old + new, LSB first, with one carry and one borrow.
    always_comb begin
        add_bit = r_sum[0] ^ r_new[0] ^ r_carry;
        sub_bit = add_bit ^ r_old[0] ^ r_borrow;
    end

    // The average is sum*255/1024 divided by the count; the low ten bits
    // of the product can go first without changing the floor.
    always_comb begin
        num   = {r_sum, 8'b0} - NUM_W'(r_sum);
        a_ext = EXT_W'(num[NUM_W-1:10]);
    end

    // One restoring division step.
    always_comb begin
        trial      = {r_rem, r_dvd[QB-1]};
        trial_ge   = (trial >= {1'b0, r_count});
        trial_diff = trial - {1'b0, r_count};
    end

    always_comb begin
        x_val = (r_q > QB'(255)) ? 8'd255 : r_q[7:0];
        level = MAX_LEVEL - GAMMA_LUT[~x_val];
        if (level == '0) begin
            level = MIN_LEVEL;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_wptr       = r_wptr;
        n_count      = r_count;
        n_sum        = r_sum;
        n_ctr        = r_ctr;
        n_carry      = r_carry;
        n_borrow     = r_borrow;
        n_out_valid  = r_out_valid;
        n_new        = r_new;
        n_old        = r_old;
        n_rem        = r_rem;
        n_dvd        = r_dvd;
        n_q          = r_q;
        n_brightness = r_brightness;

        if (r_out_valid && o_level.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_new   = i_sample.light_sample[SAMPLE_BITS-1:0];
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // The replaced entry leaves the sum only once the ring is full.
                n_old    = full ? ram_rdata : '0;
                n_carry  = 1'b0;
                n_borrow = 1'b0;
                n_ctr    = CTR_W'(SUM_W - 1);
                n_wptr   = (r_wptr == PTR_W'(WINDOW - 1)) ? '0 : r_wptr + 1'b1;
                if (!full) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum    = {sub_bit, r_sum[SUM_W-1:1]};
                n_new    = r_new >> 1;
                n_old    = r_old >> 1;
                n_carry  = (r_sum[0] & r_new[0]) | (r_sum[0] & r_carry)
                         | (r_new[0] & r_carry);
                n_borrow = (~add_bit & r_old[0]) | (~(add_bit ^ r_old[0]) & r_borrow);
                n_ctr    = r_ctr - 1'b1;
                if (r_ctr == '0) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_rem   = a_ext[EXT_W-1:QB];
                n_dvd   = a_ext[QB-1:0];
                n_ctr   = CTR_W'(QB - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
                n_dvd = r_dvd << 1;
                n_q   = {r_q[QB-2:0], trial_ge};
                n_ctr = r_ctr - 1'b1;
                if (r_ctr == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_brightness = level;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_ctr       <= '0;
            r_carry     <= 1'b0;
            r_borrow    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_ctr       <= n_ctr;
            r_carry     <= n_carry;
            r_borrow    <= n_borrow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new        <= n_new;
        r_old        <= n_old;
        r_rem        <= n_rem;
        r_dvd        <= n_dvd;
        r_q          <= n_q;
        r_brightness <= n_brightness;
    end

    assign o_level.valid      = r_out_valid;
    assign o_level.brightness = r_brightness;
endmodule

// ===== rtl/alab_checker.sv =====
// ----------------------------------------------------------------------------
// alab_checker
// Port-level checks for the ambient light brightness block.
// ----------------------------------------------------------------------------
module alab_checker import alab_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [BRIGHT_W-1:0] i_brightness
);
    // A stalled result item stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_brightness))
        else $error("brightness item changed while stalled");

    // The clamp keeps every result at one or above.
    a_level_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_brightness >= MIN_LEVEL)
        else $error("brightness below minimum");

    // One sample at a time: after an accept the input closes.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while busy");

    // Reset leaves the block idle with nothing pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");
endmodule

bind ambient_light_auto_brightness alab_checker u_alab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_level.valid),
    .i_out_ready (o_level.ready),
    .i_brightness(o_level.brightness)
);
